// File: hdl/crab_pkg.sv
package crab_pkg;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 63;
    localparam int CFG_W = 11;
    localparam logic [10:0] RESET_WIDTH = 11'd800;
    localparam logic [10:0] RESET_HEIGHT = 11'd600;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_DRAW = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        REG_WIDTH = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_RMW_READ,
        ST_RMW_WAIT,
        ST_BLEND,
        ST_WRITE,
        ST_RD_WAIT,
        ST_RD_DATA,
        ST_DONE
    } state_t;
endpackage

// File: hdl/crab_blend.sv
module crab_blend
(
    input  logic       clk,
    input  logic [7:0] a,
    input  logic [7:0] src,
    input  logic [7:0] dst,
    output logic [7:0] result
);
    import crab_pkg::*;

    logic [15:0] num_reg;
    logic [24:0] prod;

    // Registered numerator, then exact floor divide by 255 via reciprocal.
    always_ff @(posedge clk)
    begin
        num_reg <= 16'(a * src) + 16'((8'd255 - a) * dst);
    end

    assign prod = 25'(num_reg) * 25'd257 + 25'd257;
    assign result = prod[23:16];
endmodule

// File: hdl/circle_raster_alpha_blend.sv
// Filled circle rasterizer with alpha blending into an RGBA frame store.
// Input channel (in_valid/in_ready) carries one item: clear, draw, read or no action.
// Output channel (out_valid/out_ready) returns exactly one result per item.
// Configuration writes (cfg_we/cfg_index/cfg_data) set canvas width and
// height; they are taken in any cycle while the block is idle.
// One item is worked at a time. in_ready is high only while idle, so a new
// item can transfer in the cycle after the previous result transfers.
// The result becomes valid once the item's work is done:
//   clear: width*height store words are zeroed, one word written per cycle;
//   draw: each position of the (2r+1)^2 bounding box is scanned and stepped
//   past; a pixel inside canvas and circle is also read, its data registered,
//   blended and written, with r saturated to MAX_RADIUS, so at most 127*127
//   box positions for the default radius limit;
//   read: the addressed store word is read and registered; unused action: no work.
// The result stays in the output register while the receiver stalls.
// After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT words,
// one per cycle, before the first item is accepted.
module circle_raster_alpha_blend #(
    parameter int MAX_WIDTH = crab_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crab_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = crab_pkg::DEF_MAX_RADIUS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic signed [11:0] center_x,
    input  logic signed [11:0] center_y,
    input  logic [7:0]  radius,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    input  logic [9:0]  read_x,
    input  logic [9:0]  read_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_red,
    output logic [7:0]  pixel_green,
    output logic [7:0]  pixel_blue,
    output logic [7:0]  pixel_alpha,
    output logic [13:0] pixels_covered
);
    import crab_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int DW = RW + 2;
    localparam logic [10:0] MAXW11 = 11'(MAX_WIDTH > 2047 ? 2047 : MAX_WIDTH);
    localparam logic [10:0] MAXH11 = 11'(MAX_HEIGHT > 2047 ? 2047 : MAX_HEIGHT);
    localparam logic [7:0] MAXR8 = 8'(MAX_RADIUS);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    logic [10:0] width_reg, height_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WIDTH:  width_reg <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    logic [10:0] w_eff, h_eff;
    assign w_eff = (width_reg > MAXW11) ? MAXW11 : width_reg;
    assign h_eff = (height_reg > MAXH11) ? MAXH11 : height_reg;

    state_t state_reg, state_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic [AW:0] clr_end_reg, clr_end_next;
    logic signed [DW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [RW-1:0] r_reg, r_next;
    logic signed [12:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [7:0] sr_reg, sg_reg, sb_reg, sa_reg;
    logic [9:0] rx_reg, ry_reg;
    logic [AW-1:0] addr_reg, addr_next;
    logic [13:0] count_reg, count_next;
    logic [31:0] pix_reg, pix_next;
    logic out_valid_reg, out_valid_next;
    logic [2*DW-1:0] sq_reg, sq_next;
    logic [31:0] blended;

    crab_blend u_r (.clk(clk), .a(sa_reg), .src(sr_reg), .dst(rdata_reg[7:0]),
                    .result(blended[7:0]));
    crab_blend u_g (.clk(clk), .a(sa_reg), .src(sg_reg), .dst(rdata_reg[15:8]),
                    .result(blended[15:8]));
    crab_blend u_b (.clk(clk), .a(sa_reg), .src(sb_reg), .dst(rdata_reg[23:16]),
                    .result(blended[23:16]));
    crab_blend u_a (.clk(clk), .a(sa_reg), .src(sa_reg), .dst(rdata_reg[31:24]),
                    .result(blended[31:24]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clr_end_reg <= clr_end_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        r_reg <= r_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        addr_reg <= addr_next;
        count_reg <= count_next;
        pix_reg <= pix_next;
        sq_reg <= sq_next;
        if (in_valid && in_ready)
        begin
            sr_reg <= red;
            sg_reg <= green;
            sb_reg <= blue;
            sa_reg <= alpha;
            rx_reg <= read_x;
            ry_reg <= read_y;
        end
    end

    // Scan position and its clip and radius tests.
    logic signed [13:0] px, py;
    logic inside_canvas, inside_circle;
    logic [2*DW-1:0] dx_sq;
    logic [2*RW-1:0] r_sq;
    logic signed [DW-1:0] dy_step;
    assign px = 14'(cx_reg) + 14'(dx_reg);
    assign py = 14'(cy_reg) + 14'(dy_reg);
    assign inside_canvas = !px[13] && !py[13] && (px < $signed({3'b0, w_eff}))
                           && (py < $signed({3'b0, h_eff}));
    assign dx_sq = (2*DW)'(dx_reg * dx_reg);
    assign r_sq = r_reg * r_reg;
    assign inside_circle = (dx_sq + sq_reg) <= (2*DW)'(r_sq);
    assign dy_step = dy_reg + DW'(1);

    logic [7:0] r_sat;
    assign r_sat = (radius > MAXR8) ? MAXR8 : radius;

    logic [AW+1:0] pix_addr;
    assign pix_addr = (AW+2)'($unsigned(py[11:0]) * w_eff) + (AW+2)'($unsigned(px[11:0]));
    logic [AW+1:0] rd_addr;
    assign rd_addr = (AW+2)'(ry_reg * w_eff) + (AW+2)'(rx_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        clr_end_next = clr_end_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        r_next = r_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        addr_next = addr_reg;
        count_next = count_reg;
        pix_next = pix_reg;
        sq_next = sq_reg;
        out_valid_next = out_valid_reg;
        mem_we = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '0;
        mem_raddr = addr_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                pix_next = '0;
                count_next = '0;
                if (in_valid)
                begin
                    unique case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            cnt_next = '0;
                            clr_end_next = (AW+1)'(w_eff * h_eff);
                            state_next = ST_CLEAR;
                        end
                        ACT_DRAW:
                        begin
                            r_next = RW'(r_sat);
                            dx_next = -$signed(DW'(r_sat));
                            dy_next = -$signed(DW'(r_sat));
                            sq_next = (2*DW)'(r_sat * r_sat);
                            cx_next = 13'(center_x);
                            cy_next = 13'(center_y);
                            state_next = ST_SCAN;
                        end
                        ACT_READ:  state_next = ST_RD_WAIT;
                        ACT_NONE:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (cnt_reg >= clr_end_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                addr_next = pix_addr[AW-1:0];
                if (inside_canvas && inside_circle)
                begin
                    state_next = ST_RMW_READ;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_RMW_READ: state_next = ST_RMW_WAIT;
            ST_RMW_WAIT: state_next = ST_BLEND;
            ST_BLEND:
            begin
                mem_we = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = blended;
                count_next = count_reg + 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Step to the next box position; the row's dy squared is kept.
                if (dx_reg == $signed(DW'(r_reg)))
                begin
                    if (dy_reg == $signed(DW'(r_reg)))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        dx_next = -$signed(DW'(r_reg));
                        dy_next = dy_step;
                        sq_next = (2*DW)'(dy_step * dy_step);
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_RD_WAIT:
            begin
                mem_raddr = rd_addr[AW-1:0];
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if ({1'b0, rx_reg} < w_eff && {1'b0, ry_reg} < h_eff)
                begin
                    pix_next = rdata_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                if (out_valid_reg && out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pixel_red = pix_reg[7:0];
    assign pixel_green = pix_reg[15:8];
    assign pixel_blue = pix_reg[23:16];
    assign pixel_alpha = pix_reg[31:24];
    assign pixels_covered = count_reg;
endmodule
